@@ rtl/bls_pkg.sv @@
// Shared widths, codes and types for the box line side and crossing block.
`default_nettype none

package bls_pkg;

  // Coordinate width of the box corners and the line points
  localparam int COORD_BITS = 16;

  // Offsets from the line start; the center sum in doubled units needs two extra bits
  localparam int OFS_BITS   = COORD_BITS + 2;
  // Line direction components
  localparam int DIR_BITS   = COORD_BITS + 1;
  // One product and the cross product difference
  localparam int PROD_BITS  = OFS_BITS + DIR_BITS;
  localparam int CROSS_BITS = PROD_BITS + 1;

  // Tolerance, raw and doubled for the center policy
  localparam int TOL_BITS   = 32;
  localparam int TOLE_BITS  = TOL_BITS + 1;

  // Common signed width for the tolerance band compare
  localparam int CMP_BITS   = (CROSS_BITS > TOLE_BITS + 1) ? CROSS_BITS : TOLE_BITS + 1;

  // Configuration port
  localparam int CFG_W        = (COORD_BITS > TOL_BITS) ? COORD_BITS : TOL_BITS;
  localparam int CFG_IDX_BITS = 3;

  // Number of corner lanes
  localparam int LANES = 4;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_START_X   = 3'd0,
    REG_START_Y   = 3'd1,
    REG_END_X     = 3'd2,
    REG_END_Y     = 3'd3,
    REG_POLICY    = 3'd4,
    REG_DIRECTION = 3'd5,
    REG_TOLERANCE = 3'd6
  } cfg_reg_t;

  // Side codes
  localparam logic [1:0] SIDE_ON      = 2'd0;
  localparam logic [1:0] SIDE_LEFT    = 2'd1;
  localparam logic [1:0] SIDE_RIGHT   = 2'd2;
  // Unused code, never a valid side
  localparam logic [1:0] SIDE_INVALID = 2'd3;

  // Side policies
  localparam logic [1:0] POL_CENTER = 2'd0;
  localparam logic [1:0] POL_ANY    = 2'd1;
  localparam logic [1:0] POL_ALL    = 2'd2;

  // Allowed crossing directions
  localparam logic [1:0] DIR_ANY    = 2'd0;
  localparam logic [1:0] DIR_L2R    = 2'd1;
  localparam logic [1:0] DIR_R2L    = 2'd2;

  // Register file contents and values derived from them
  typedef struct packed {
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [DIR_BITS-1:0]   dir_x;
    logic signed [DIR_BITS-1:0]   dir_y;
    logic [1:0]                   policy;
    logic [1:0]                   direction;
    logic [TOLE_BITS-1:0]         tol_eff;
  } cfg_t;

  // Load enables of the lane stages
  typedef struct packed {
    logic mul;
    logic sub;
    logic cls;
  } lane_en_t;

endpackage

`default_nettype wire

@@ rtl/bls_cfg.sv @@
// Configuration registers and the line direction and tolerance derived from them.
`default_nettype none

module bls_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bls_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [bls_pkg::CFG_W-1:0]        cfg_data,
  output bls_pkg::cfg_t                    cfg
);
  import bls_pkg::*;

  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic [1:0]                   policy;
  logic [1:0]                   direction;
  logic [TOL_BITS-1:0]          tolerance;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_x   <= '0;
      start_y   <= '0;
      end_x     <= COORD_BITS'(1);
      end_y     <= '0;
      policy    <= POL_CENTER;
      direction <= DIR_ANY;
      tolerance <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_X:   start_x   <= cfg_data[COORD_BITS-1:0];
        REG_START_Y:   start_y   <= cfg_data[COORD_BITS-1:0];
        REG_END_X:     end_x     <= cfg_data[COORD_BITS-1:0];
        REG_END_Y:     end_y     <= cfg_data[COORD_BITS-1:0];
        REG_POLICY:    policy    <= cfg_data[1:0];
        REG_DIRECTION: direction <= cfg_data[1:0];
        REG_TOLERANCE: tolerance <= cfg_data[TOL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Direction vector; the center policy works in doubled units, so the band doubles too
  always_comb begin
    cfg.start_x   = start_x;
    cfg.start_y   = start_y;
    cfg.dir_x     = DIR_BITS'(end_x) - DIR_BITS'(start_x);
    cfg.dir_y     = DIR_BITS'(end_y) - DIR_BITS'(start_y);
    cfg.policy    = policy;
    cfg.direction = direction;
    cfg.tol_eff   = (policy == POL_CENTER) ? {tolerance, 1'b0} : {1'b0, tolerance};
  end

endmodule

`default_nettype wire

@@ rtl/bls_lane.sv @@
// One point lane: cross product multiply, subtract and tolerance band classify.
`default_nettype none

module bls_lane (
  input  logic                               clk,
  input  bls_pkg::lane_en_t                  en,
  input  logic signed [bls_pkg::OFS_BITS-1:0] ofs_x,
  input  logic signed [bls_pkg::OFS_BITS-1:0] ofs_y,
  input  logic signed [bls_pkg::DIR_BITS-1:0] dir_x,
  input  logic signed [bls_pkg::DIR_BITS-1:0] dir_y,
  input  logic [bls_pkg::TOLE_BITS-1:0]       tol_eff,
  output logic [1:0]                          side
);
  import bls_pkg::*;

  logic signed [PROD_BITS-1:0]  prod_a;
  logic signed [PROD_BITS-1:0]  prod_b;
  logic signed [CROSS_BITS-1:0] cross_prod;
  logic signed [CMP_BITS-1:0]   cross_w;
  logic signed [CMP_BITS-1:0]   tol_w;
  logic [1:0]                   side_next;

  // Multiply stage: dir_x * (py - sy) and dir_y * (px - sx)
  always_ff @(posedge clk) begin
    if (en.mul) begin
      prod_a <= dir_x * ofs_y;
      prod_b <= dir_y * ofs_x;
    end
  end

  // Subtract stage
  always_ff @(posedge clk) begin
    if (en.sub) begin
      cross_prod <= CROSS_BITS'(prod_a) - CROSS_BITS'(prod_b);
    end
  end

  // Classify: inside [-tol, tol] is on the line, else the sign decides
  always_comb begin
    cross_w = CMP_BITS'(cross_prod);
    tol_w   = CMP_BITS'($signed({1'b0, tol_eff}));
    if ((cross_w <= tol_w) && (cross_w >= -tol_w)) begin
      side_next = SIDE_ON;
    end else if (cross_w < 0) begin
      side_next = SIDE_RIGHT;
    end else begin
      side_next = SIDE_LEFT;
    end
  end

  always_ff @(posedge clk) begin
    if (en.cls) begin
      side <= side_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/bls_decide.sv @@
// Merges the corner sides under the policy and checks the crossing rule.
`default_nettype none

module bls_decide (
  input  logic [bls_pkg::LANES-1:0][1:0] lane_side,
  input  logic [1:0]                     policy,
  input  logic [1:0]                     direction,
  input  logic [1:0]                     previous_side,
  output logic [1:0]                     current_side,
  output logic                           crossed
);
  import bls_pkg::*;

  logic [1:0] any_side;
  logic       clash;
  logic [1:0] all_side;

  // Any corner: skip corners on the line, disagreement gives on
  always_comb begin
    any_side = SIDE_ON;
    clash    = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      if (lane_side[i] != SIDE_ON) begin
        if (any_side == SIDE_ON) begin
          any_side = lane_side[i];
        end else if (any_side != lane_side[i]) begin
          clash = 1'b1;
        end
      end
    end
    if (clash) begin
      any_side = SIDE_ON;
    end
  end

  // All corners: on unless every corner agrees
  always_comb begin
    all_side = lane_side[0];
    for (int i = 1; i < LANES; i++) begin
      if (lane_side[i] != lane_side[0]) begin
        all_side = SIDE_ON;
      end
    end
  end

  // Policy select; the center point travels in lane 0
  always_comb begin
    unique case (policy)
      POL_CENTER: current_side = lane_side[0];
      POL_ANY:    current_side = any_side;
      POL_ALL:    current_side = all_side;
      default:    current_side = SIDE_ON;
    endcase
  end

  // Crossing rule; an invalid previous side never crosses
  always_comb begin
    crossed = 1'b0;
    if ((previous_side != SIDE_INVALID) && (previous_side != current_side)) begin
      if ((previous_side == SIDE_ON) || (current_side == SIDE_ON)) begin
        crossed = (direction == DIR_ANY);
      end else begin
        unique case (direction)
          DIR_ANY: crossed = 1'b1;
          DIR_L2R: crossed = (previous_side == SIDE_LEFT) && (current_side == SIDE_RIGHT);
          DIR_R2L: crossed = (previous_side == SIDE_RIGHT) && (current_side == SIDE_LEFT);
          default: crossed = 1'b0;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/box_line_side_and_crossing.sv @@
// Box against directed line: side and crossing, five register stages.
// A transaction runs through the offset, product, cross and side registers to out_valid.
// Throughput: one transaction per cycle while out_stall is low; the stall chain frees a stage as soon as
// the one after it moves, and the output register is the slowest point only when stalled.
// Reset (rst, synchronous): clears every stage valid and loads the register reset values.
`default_nettype none

module box_line_side_and_crossing (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [bls_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [bls_pkg::CFG_W-1:0]          cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [bls_pkg::COORD_BITS-1:0] box_min_x,
  input  logic signed [bls_pkg::COORD_BITS-1:0] box_min_y,
  input  logic signed [bls_pkg::COORD_BITS-1:0] box_max_x,
  input  logic signed [bls_pkg::COORD_BITS-1:0] box_max_y,
  input  logic [1:0]                         previous_side,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         current_side,
  output logic                               crossed
);
  import bls_pkg::*;

  cfg_t     cfg;
  lane_en_t lane_en;

  // Stage valids: 1 offsets, 2 products, 3 cross, 4 sides; out_valid is stage 5
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  logic [1:0] prev1, prev2, prev3, prev4;

  logic signed [OFS_BITS-1:0] ofs_x [LANES];
  logic signed [OFS_BITS-1:0] ofs_y [LANES];
  logic signed [OFS_BITS-1:0] ofs_x_next [LANES];
  logic signed [OFS_BITS-1:0] ofs_y_next [LANES];

  logic [LANES-1:0][1:0] lane_side;
  logic [1:0]            side_next;
  logic                  crossed_next;

  bls_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Stall chain: a stage loads when it is empty or the next one moves
  assign rdy5     = !out_valid || !out_stall;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;

  assign lane_en.mul = rdy2;
  assign lane_en.sub = rdy3;
  assign lane_en.cls = rdy4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) out_valid <= v4;
    end
  end

  // Point offsets from the line start; center in doubled units sits in lane 0
  always_comb begin
    logic signed [OFS_BITS-1:0] x0, y0, x1, y1, sx, sy;
    x0 = OFS_BITS'(box_min_x);
    y0 = OFS_BITS'(box_min_y);
    x1 = OFS_BITS'(box_max_x);
    y1 = OFS_BITS'(box_max_y);
    sx = OFS_BITS'(cfg.start_x);
    sy = OFS_BITS'(cfg.start_y);
    if (cfg.policy == POL_CENTER) begin
      ofs_x_next[0] = x0 + x1 - (sx <<< 1);
      ofs_y_next[0] = y0 + y1 - (sy <<< 1);
    end else begin
      ofs_x_next[0] = x0 - sx;
      ofs_y_next[0] = y0 - sy;
    end
    ofs_x_next[1] = x1 - sx;
    ofs_y_next[1] = y0 - sy;
    ofs_x_next[2] = x1 - sx;
    ofs_y_next[2] = y1 - sy;
    ofs_x_next[3] = x0 - sx;
    ofs_y_next[3] = y1 - sy;
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      ofs_x <= ofs_x_next;
      ofs_y <= ofs_y_next;
      prev1 <= previous_side;
    end
  end

  // Previous side rides along with the lanes
  always_ff @(posedge clk) begin
    if (rdy2) prev2 <= prev1;
    if (rdy3) prev3 <= prev2;
    if (rdy4) prev4 <= prev3;
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    bls_lane u_lane (
      .clk     (clk),
      .en      (lane_en),
      .ofs_x   (ofs_x[g]),
      .ofs_y   (ofs_y[g]),
      .dir_x   (cfg.dir_x),
      .dir_y   (cfg.dir_y),
      .tol_eff (cfg.tol_eff),
      .side    (lane_side[g])
    );
  end

  bls_decide u_decide (
    .lane_side     (lane_side),
    .policy        (cfg.policy),
    .direction     (cfg.direction),
    .previous_side (prev4),
    .current_side  (side_next),
    .crossed       (crossed_next)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rdy5) begin
      current_side <= side_next;
      crossed      <= crossed_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/bls_check.sv @@
// Port level checks for the box line side and crossing block, bound to the top level.
`default_nettype none

module bls_check (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [1:0]                         current_side,
  input logic                               crossed
);
  import bls_pkg::*;

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(current_side) && $stable(crossed))
    else $error("stalled result changed");

  // The unused side code is never produced
  a_side_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> current_side != SIDE_INVALID)
    else $error("invalid side code on output");

  // With the output not stalled in between, an accepted transaction shows up on out_valid
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall
    |=> out_valid)
    else $error("result missing after pipeline latency");

endmodule

bind box_line_side_and_crossing bls_check u_bls_check (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .current_side (current_side),
  .crossed      (crossed)
);

`default_nettype wire
